>>> src/cnlc_pkg.sv
// ----------------------------------------------------------------------------
// cnlc_pkg: shared types and constants for the card number check
// Holds the fixed field widths, card kind codes and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package cnlc_pkg;

    // Fixed field widths.
    localparam int BIN_W      = 54;
    localparam int BCD_DIGITS = 17;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int COUNT_W    = 5;
    localparam int SUM_W      = 8;
    localparam int KIND_W     = 3;
    localparam int STEP_W     = 6;

    // Shortest accepted card number.
    localparam logic [COUNT_W-1:0] LEN_MIN = 5'd13;

    // Card kind codes.
    localparam logic [KIND_W-1:0] KIND_VISA     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MASTER   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_AMEX     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DISCOVER = 3'd3;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN  = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load;
        logic                conv_step;
        logic                scan_step;
        logic [COUNT_W-1:0]  scan_index;
        logic                publish;
    } cnlc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } cnlc_stat_t;

    // Luhn value of a digit in an odd place: doubled, with its digits added.
    function automatic logic [3:0] luhn_double(input logic [3:0] d);
        logic [4:0] twice;
        begin
            twice = {d, 1'b0};
            if (twice > 5'd9)
            begin
                twice = twice - 5'd9;
            end
            return twice[3:0];
        end
    endfunction

endpackage

>>> src/card_number_luhn_check.sv
// ----------------------------------------------------------------------------
// card_number_luhn_check: Luhn mod-10 check of a binary card number
//
// Usage:
//   The input channel (in_valid, in_stall, card_number) takes one card number
//   as an unsigned binary integer. The output channel (out_valid, out_stall,
//   digit_count, length_ok, card_kind, luhn_sum, checksum_ok) returns one
//   result item for each input item, in order.
//   An item is converted to decimal one bit per cycle by the shift-add-3
//   loop, then its 17 decimal digits are scanned one per cycle, and the
//   result is written into the output register once that register can take
//   it. A new item is accepted only after the last one has been written into
//   the output register. in_stall is high while an item is at work.
//   A stalled result waits in the output register while the next item is
//   already accepted and processed; that item then waits for the register.
//   Reset clears the sequencer and the output valid flag; the block is idle
//   and ready for an item right after reset.
// ----------------------------------------------------------------------------
module card_number_luhn_check
#(
    parameter int MAX_DIGITS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [cnlc_pkg::BIN_W-1:0]        card_number,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [cnlc_pkg::COUNT_W-1:0]      digit_count,
    output logic                              length_ok,
    output logic [cnlc_pkg::KIND_W-1:0]       card_kind,
    output logic [cnlc_pkg::SUM_W-1:0]        luhn_sum,
    output logic                              checksum_ok
);
    import cnlc_pkg::*;

    cnlc_cmd_t  cmd;
    cnlc_stat_t stat;

    // Sequencer.
    cnlc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Conversion, scan and output register.
    cnlc_datapath
    #(
        .MAX_DIGITS (MAX_DIGITS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .card_number (card_number),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digit_count (digit_count),
        .length_ok   (length_ok),
        .card_kind   (card_kind),
        .luhn_sum    (luhn_sum),
        .checksum_ok (checksum_ok)
    );

endmodule

>>> src/cnlc_ctrl.sv
// ----------------------------------------------------------------------------
// cnlc_ctrl: sequencer for the card number check
// Steps the datapath through the binary to decimal conversion, the digit
// scan and the hand-off of the result into the output register.
// ----------------------------------------------------------------------------
module cnlc_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  cnlc_pkg::cnlc_stat_t stat,
    output cnlc_pkg::cnlc_cmd_t  cmd
);
    import cnlc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_PUBLISH
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;

    // A new item is taken only while the sequencer is idle.
    assign in_stall = (state_reg != ST_IDLE);

    // Next state and step counter.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CONV;
                    step_next  = '0;
                end
            end
            ST_CONV:
            begin
                if (step_reg == STEP_W'(BIN_W - 1))
                begin
                    state_next = ST_SCAN;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (step_reg == STEP_W'(BCD_DIGITS - 1))
                begin
                    state_next = ST_PUBLISH;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_PUBLISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Commands decoded from the state.
    always_comb
    begin
        cmd.load       = (state_reg == ST_IDLE) && in_valid;
        cmd.conv_step  = (state_reg == ST_CONV);
        cmd.scan_step  = (state_reg == ST_SCAN);
        cmd.scan_index = step_reg[COUNT_W-1:0];
        cmd.publish    = (state_reg == ST_PUBLISH) && stat.out_free;
    end

    // The output register is written only when it can take a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> stat.out_free)
        else $error("result published into a full output register");

    // Conversion runs exactly one step per input bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV) |-> (step_reg < STEP_W'(BIN_W)))
        else $error("conversion step counter out of range");

    // The scan visits each decimal digit once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (step_reg < STEP_W'(BCD_DIGITS)))
        else $error("scan step counter out of range");

    // An accepted item always starts the conversion.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_CONV) && (step_reg == '0))
        else $error("accepted item did not start the conversion");

endmodule

>>> src/cnlc_datapath.sv
// ----------------------------------------------------------------------------
// cnlc_datapath: conversion, digit scan and output register
// Converts the binary card number to decimal one bit per cycle, scans the
// digits from the right one per cycle and holds the finished result.
// ----------------------------------------------------------------------------
module cnlc_datapath
#(
    parameter int MAX_DIGITS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  cnlc_pkg::cnlc_cmd_t               cmd,
    output cnlc_pkg::cnlc_stat_t              stat,
    input  logic [cnlc_pkg::BIN_W-1:0]        card_number,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [cnlc_pkg::COUNT_W-1:0]      digit_count,
    output logic                              length_ok,
    output logic [cnlc_pkg::KIND_W-1:0]       card_kind,
    output logic [cnlc_pkg::SUM_W-1:0]        luhn_sum,
    output logic                              checksum_ok
);
    import cnlc_pkg::*;

    // Working registers.
    logic [BIN_W-1:0]    bin_reg;
    logic [BCD_W-1:0]    bcd_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [3:0]          res_reg;
    logic [3:0]          hi_reg;
    logic [3:0]          lo_reg;
    logic [3:0]          prev_reg;

    // Output registers.
    logic                out_valid_reg;
    logic [COUNT_W-1:0]  digit_count_reg;
    logic                length_ok_reg;
    logic [KIND_W-1:0]   card_kind_reg;
    logic [SUM_W-1:0]    luhn_sum_reg;
    logic                checksum_ok_reg;

    // Combinational helpers.
    logic [BCD_W-1:0]    bcd_adj;
    logic [3:0]          digit;
    logic [3:0]          digit_val;
    logic [4:0]          res_sum;
    logic [3:0]          res_next;
    logic                len_ok_next;
    logic [KIND_W-1:0]   kind_next;

    // Add three to every decimal digit of five or more before the shift.
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // Current digit and its Luhn weight; the running sum modulo ten.
    always_comb
    begin
        digit     = bcd_reg[3:0];
        digit_val = cmd.scan_index[0] ? luhn_double(digit) : digit;
        res_sum   = {1'b0, res_reg} + {1'b0, digit_val};
        if (res_sum >= 5'd10)
        begin
            res_next = 4'(res_sum - 5'd10);
        end
        else
        begin
            res_next = res_sum[3:0];
        end
    end

    // Length window and card kind from the leading two digits.
    always_comb
    begin
        len_ok_next = (count_reg >= LEN_MIN) && (count_reg <= COUNT_W'(MAX_DIGITS));
        kind_next   = KIND_UNKNOWN;
        if (count_reg >= 5'd2)
        begin
            case (hi_reg)
                4'd4:    kind_next = KIND_VISA;
                4'd5:    kind_next = KIND_MASTER;
                4'd6:    kind_next = KIND_DISCOVER;
                4'd3:    kind_next = (lo_reg == 4'd7) ? KIND_AMEX : KIND_UNKNOWN;
                default: kind_next = KIND_UNKNOWN;
            endcase
        end
    end

    // Conversion and scan registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg   <= card_number;
            bcd_reg   <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            res_reg   <= '0;
            hi_reg    <= '0;
            lo_reg    <= '0;
            prev_reg  <= '0;
        end
        else if (cmd.conv_step)
        begin
            bcd_reg <= {bcd_adj[BCD_W-2:0], bin_reg[BIN_W-1]};
            bin_reg <= {bin_reg[BIN_W-2:0], 1'b0};
        end
        else if (cmd.scan_step)
        begin
            sum_reg  <= sum_reg + {4'b0, digit_val};
            res_reg  <= res_next;
            prev_reg <= digit;
            bcd_reg  <= {4'b0, bcd_reg[BCD_W-1:4]};
            if (digit != 4'd0)
            begin
                count_reg <= cmd.scan_index + 5'd1;
                hi_reg    <= digit;
                lo_reg    <= prev_reg;
            end
        end
    end

    // The output register can take a result when empty or being read.
    assign stat.out_free = !out_valid_reg || !out_stall;

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            digit_count_reg <= count_reg;
            length_ok_reg   <= len_ok_next;
            card_kind_reg   <= kind_next;
            luhn_sum_reg    <= sum_reg;
            checksum_ok_reg <= len_ok_next && (res_reg == 4'd0);
        end
    end

    assign out_valid   = out_valid_reg;
    assign digit_count = digit_count_reg;
    assign length_ok   = length_ok_reg;
    assign card_kind   = card_kind_reg;
    assign luhn_sum    = luhn_sum_reg;
    assign checksum_ok = checksum_ok_reg;

    // A passing checksum needs an acceptable length.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!checksum_ok_reg || length_ok_reg))
        else $error("checksum passed with a bad length");

    // A zero number has no leading digits and so no known kind.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (digit_count_reg == '0)) |-> (card_kind_reg == KIND_UNKNOWN))
        else $error("zero number given a card kind");

    // The residue modulo ten stays a single decimal digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |=> (res_reg <= 4'd9))
        else $error("Luhn residue out of range");

endmodule
